// ===== hdl/mafd_pkg.sv =====
// shared types, constants and character decode functions for the modbus ascii
// frame decoder; no dependencies
`default_nettype none

package mafd_pkg;

  localparam int MAX_FRAME_CHARS = 128;
  localparam int CNT_W = $clog2(MAX_FRAME_CHARS + 2);
  localparam int MIN_FRAME_CHARS = 7;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [5:0] DATA_COUNT_MAX = 6'd63;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_ODD   = 3'd2,
    ST_HEX   = 3'd3,
    ST_LRC   = 3'd4,
    ST_OVER  = 3'd5
  } status_t;

  typedef struct packed {
    logic       first_was_colon;
    logic       low_nibble_next;
    logic [3:0] high_nibble;
    logic [7:0] held_byte;
    logic       held_valid;
    logic [7:0] running_sum;
    logic       hex_bad;
    logic [5:0] data_count;
  } frame_t;

  typedef struct packed {
    frame_t     f;
    logic       rel_valid;
    logic [7:0] rel;
  } take_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] data_byte;
    status_t    status;
    logic [5:0] frame_bytes;
  } res_t;

  // returns {bad, nibble}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else begin
      r = 5'b1_0000;
    end
    return r;
  endfunction

  // one frame character through the pair decoder
  function automatic take_t take_char(input frame_t f, input logic [7:0] c,
                                      input logic pos_zero);
    take_t      r;
    logic [4:0] nv;
    logic [7:0] b;
    r.f = f;
    r.rel_valid = 1'b0;
    r.rel = 8'd0;
    nv = nibble_of(c);
    b = {f.high_nibble, nv[3:0]};
    if (pos_zero) begin
      r.f.first_was_colon = (c == CHAR_COLON);
    end else begin
      if (nv[4]) begin
        r.f.hex_bad = 1'b1;
      end
      if (!f.low_nibble_next) begin
        r.f.high_nibble = nv[3:0];
        r.f.low_nibble_next = 1'b1;
      end else begin
        r.f.low_nibble_next = 1'b0;
        r.f.held_byte = b;
        if (f.held_valid) begin
          r.rel_valid = 1'b1;
          r.rel = f.held_byte;
          r.f.running_sum = f.running_sum + f.held_byte;
          if (f.data_count != DATA_COUNT_MAX) begin
            r.f.data_count = f.data_count + 6'd1;
          end
        end else begin
          r.f.held_valid = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mafd_in_reg.sv =====
// input register for received characters
// depends on mafd_pkg
`default_nettype none

module mafd_in_reg import mafd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_char,
  input  wire logic       advance,
  output logic            char_valid,
  output logic [7:0]      char_q
);

  assign rx_stall = char_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!rx_stall) begin
      char_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      char_q <= rx_char;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mafd_core.sv =====
// frame state and per-character decode: pair assembly, lrc sum, frame status
// depends on mafd_pkg
`default_nettype none

module mafd_core import mafd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] c,
  output logic            res_load,
  output res_t            res
);

  logic [CNT_W-1:0] char_count;
  logic [CNT_W-1:0] char_count_next;
  logic             cr_pending;
  logic             cr_pending_next;
  frame_t           frame;
  frame_t           frame_next;

  logic [CNT_W-1:0] len;
  logic             lf_end;
  logic             over;
  take_t            t1;
  take_t            t2;
  status_t          end_status;

  always_comb begin
    len = char_count + CNT_W'(1);
    lf_end = cr_pending && (c == CHAR_LF);

    if (len < CNT_W'(MIN_FRAME_CHARS) || !frame.first_was_colon) begin
      end_status = ST_SHORT;
    end else if (!len[0]) begin
      end_status = ST_ODD;
    end else if (frame.hex_bad) begin
      end_status = ST_HEX;
    end else if (frame.held_byte != 8'(8'd0 - frame.running_sum)) begin
      end_status = ST_LRC;
    end else begin
      end_status = ST_OK;
    end

    // pending cr resolved as an ordinary frame character
    if (cr_pending) begin
      t1 = take_char(frame, CHAR_CR, char_count == CNT_W'(1));
    end else begin
      t1 = '{f: frame, rel_valid: 1'b0, rel: 8'd0};
    end
    if (c != CHAR_CR) begin
      t2 = take_char(t1.f, c, char_count == '0);
    end else begin
      t2 = '{f: t1.f, rel_valid: 1'b0, rel: 8'd0};
    end

    over = len > CNT_W'(MAX_FRAME_CHARS);

    res = '{frame_end: 1'b0, data_byte: 8'd0, status: ST_OK, frame_bytes: 6'd0};
    res_load = 1'b0;
    frame_next = t2.f;
    char_count_next = len;
    cr_pending_next = (c == CHAR_CR);

    priority if (lf_end) begin
      res.frame_end = 1'b1;
      res.status = end_status;
      res.frame_bytes = (end_status == ST_OK) ? frame.data_count : 6'd0;
      res_load = 1'b1;
      frame_next = '0;
      char_count_next = '0;
      cr_pending_next = 1'b0;
    end else if (over) begin
      res.frame_end = 1'b1;
      res.status = ST_OVER;
      res_load = 1'b1;
      frame_next = '0;
      char_count_next = '0;
      cr_pending_next = 1'b0;
    end else if (t1.rel_valid || t2.rel_valid) begin
      res.data_byte = t1.rel_valid ? t1.rel : t2.rel;
      res_load = 1'b1;
    end else begin
      res_load = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      cr_pending <= 1'b0;
      frame <= '0;
    end else if (fire) begin
      char_count <= char_count_next;
      cr_pending <= cr_pending_next;
      frame <= frame_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mafd_out_reg.sv =====
// result register for data and frame status results
// depends on mafd_pkg
`default_nettype none

module mafd_out_reg import mafd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      res_valid,
  output res_t      res_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_q <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/modbus_ascii_frame_decoder.sv =====
// modbus ascii frame decoder top level: input register, decode core, result register
// depends on mafd_pkg, mafd_in_reg, mafd_core, mafd_out_reg
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   rx      | rx_valid / rx_stall  | rx_char
//   res     | res_valid / res_stall| frame_end, data_byte, status, frame_bytes
//
// one character per cycle sustained while no result is stalled; a character
// transfer reaches the outputs through the input register, then the result register
// a character that ends a frame, completes a non-first hex pair or overflows
// the frame gives one result; other characters give none
// synchronous reset clears the frame state and both valid flags
// a stalled result holds the pipe: rx_stall rises once the input register is full
`default_nettype none

module modbus_ascii_frame_decoder import mafd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_char,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic            frame_end,
  output logic [7:0]      data_byte,
  output logic [2:0]      status,
  output logic [5:0]      frame_bytes
);

  logic       advance;
  logic       char_valid;
  logic [7:0] char_q;
  logic       res_load;
  res_t       res_next;
  res_t       res_q;

  assign advance = !(res_valid && res_stall);

  mafd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_char    (rx_char),
    .advance    (advance),
    .char_valid (char_valid),
    .char_q     (char_q)
  );

  mafd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (char_valid && advance),
    .c        (char_q),
    .res_load (res_load),
    .res      (res_next)
  );

  mafd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .load      (char_valid && res_load),
    .res_in    (res_next),
    .res_valid (res_valid),
    .res_q     (res_q)
  );

  assign frame_end   = res_q.frame_end;
  assign data_byte   = res_q.data_byte;
  assign status      = res_q.status;
  assign frame_bytes = res_q.frame_bytes;

endmodule

`default_nettype wire

// ===== hdl/mafd_checker.sv =====
// port-level checks for the modbus ascii frame decoder, bound to the top level
// depends on modbus_ascii_frame_decoder ports only
`default_nettype none

module mafd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_stall,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic       frame_end,
  input wire logic [7:0] data_byte,
  input wire logic [2:0] status,
  input wire logic [5:0] frame_bytes
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(frame_end) && $stable(data_byte)
      && $stable(status) && $stable(frame_bytes))
    else $error("stalled result changed");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_end |-> status == 3'd0 && frame_bytes == 6'd0)
    else $error("data result carries status fields");

  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_end |-> data_byte == 8'd0 && (status == 3'd0 || frame_bytes == 6'd0))
    else $error("frame status result malformed");

  // input side only stalls behind a stalled result
  a_rx_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid && res_stall)
    else $error("input stalled without a stalled result");

  // a character passes the input register before it reaches the result register
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid ##1 !res_valid)
    else $error("result too soon after reset");

endmodule

bind modbus_ascii_frame_decoder mafd_checker u_mafd_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_stall    (rx_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .frame_end   (frame_end),
  .data_byte   (data_byte),
  .status      (status),
  .frame_bytes (frame_bytes)
);

`default_nettype wire

// ===== test/mafd_frame_checker.sv =====
`timescale 1ns / 100ps
// result checker for the modbus ascii frame decoder: tracks frame state from each
// character transfer, queues the expected results and compares every result transfer
// depends on mafd_pkg
module mafd_frame_checker import mafd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  input  wire logic       rx_stall,
  input  wire logic [7:0] rx_char,
  input  wire logic       res_valid,
  input  wire logic       res_stall,
  input  wire logic       frame_end,
  input  wire logic [7:0] data_byte,
  input  wire logic [2:0] status,
  input  wire logic [5:0] frame_bytes,
  output int              mismatches,
  output int              outstanding
);

  res_t        expected_q[$];
  int          err_count = 0;

  int unsigned n_chars;
  logic        colon_first;
  logic        cr_held;
  logic        want_low;
  logic [3:0]  hi_nib;
  logic [7:0]  pair_byte;
  logic        pair_held;
  logic [7:0]  data_sum;
  logic        digit_bad;
  logic [5:0]  n_data;

  assign mismatches = err_count;

  initial outstanding = 0;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    err_count++;
    if (err_count <= 30) begin
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  task automatic clear_frame();
    n_chars = 0;
    colon_first = 1'b0;
    cr_held = 1'b0;
    want_low = 1'b0;
    hi_nib = 4'd0;
    pair_byte = 8'd0;
    pair_held = 1'b0;
    data_sum = 8'd0;
    digit_bad = 1'b0;
    n_data = 6'd0;
  endtask

  // one frame character through the hex pair decoder
  task automatic take_char(input logic [7:0] c, input int unsigned pos,
                           output logic rel_ok, output logic [7:0] rel);
    logic [3:0] v;
    rel_ok = 1'b0;
    rel = 8'd0;
    if (pos == 0) begin
      colon_first = (c == CHAR_COLON);
    end else begin
      if (c >= "0" && c <= "9") begin
        v = c[3:0];
      end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
        v = c[3:0] + 4'd9;
      end else begin
        v = 4'd0;
        digit_bad = 1'b1;
      end
      if (!want_low) begin
        hi_nib = v;
        want_low = 1'b1;
      end else begin
        want_low = 1'b0;
        if (pair_held) begin
          rel_ok = 1'b1;
          rel = pair_byte;
          data_sum = data_sum + pair_byte;
          if (n_data != DATA_COUNT_MAX) n_data = n_data + 6'd1;
        end
        pair_held = 1'b1;
        pair_byte = {hi_nib, v};
      end
    end
  endtask

  task automatic decode_rx_char(input logic [7:0] c);
    res_t        r;
    int unsigned len;
    int unsigned pos;
    logic        got_cr;
    logic        got_c;
    logic [7:0]  byte_cr;
    logic [7:0]  byte_c;
    r = '0;
    got_cr = 1'b0;
    got_c = 1'b0;
    byte_cr = 8'd0;
    byte_c = 8'd0;
    if (cr_held && c == CHAR_LF) begin
      len = n_chars + 1;
      r.frame_end = 1'b1;
      if (len < MIN_FRAME_CHARS || !colon_first) begin
        r.status = ST_SHORT;
      end else if (((len - 3) & 1) != 0) begin
        r.status = ST_ODD;
      end else if (digit_bad) begin
        r.status = ST_HEX;
      end else if (8'(pair_byte + data_sum) != 8'd0) begin
        r.status = ST_LRC;
      end else begin
        r.status = ST_OK;
        r.frame_bytes = n_data;
      end
      clear_frame();
      expected_q.insert(expected_q.size(), r);
    end else begin
      // a cr not followed by lf is an ordinary frame character
      if (cr_held) begin
        cr_held = 1'b0;
        take_char(CHAR_CR, n_chars - 1, got_cr, byte_cr);
      end
      pos = n_chars;
      n_chars++;
      if (c == CHAR_CR) begin
        cr_held = 1'b1;
      end else begin
        take_char(c, pos, got_c, byte_c);
      end
      if (n_chars > MAX_FRAME_CHARS) begin
        clear_frame();
        r.frame_end = 1'b1;
        r.status = ST_OVER;
        expected_q.insert(expected_q.size(), r);
      end else if (got_cr || got_c) begin
        r.data_byte = got_c ? byte_c : byte_cr;
        r.status = ST_OK;
        expected_q.insert(expected_q.size(), r);
      end
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      clear_frame();
      expected_q.delete();
    end else begin
      if (rx_valid && !rx_stall) decode_rx_char(rx_char);
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          report("result transfer with nothing expected", data_byte, 8'd0);
        end else begin
          e = expected_q.pop_front();
          if (frame_end !== e.frame_end) begin
            report("frame_end", 8'(frame_end), 8'(e.frame_end));
          end
          if (data_byte !== e.data_byte) report("data_byte", data_byte, e.data_byte);
          if (status !== e.status) report("status", 8'(status), 8'(e.status));
          if (frame_bytes !== e.frame_bytes) begin
            report("frame_bytes", 8'(frame_bytes), 8'(e.frame_bytes));
          end
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== test/tb_modbus_ascii_frame_decoder.sv =====
`timescale 1ns / 100ps
// testbench top for the modbus ascii frame decoder: drives directed and random
// frames with random idle and stall bursts, verdict from mafd_frame_checker
// depends on mafd_pkg, mafd_frame_checker and the decoder rtl
module tb_modbus_ascii_frame_decoder;
  import mafd_pkg::*;

  localparam int N_ITEMS = 1900;
  localparam int CALM_AT = 1600;
  localparam int HOLD_AT = 700;
  localparam int HOLD_CYCLES = 200;

  typedef enum {
    FR_GOOD, FR_LRC, FR_HEX, FR_ODD, FR_START, FR_SHORT, FR_CR, FR_LF, FR_OVER, FR_NOISE
  } frame_kind_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_char;
  logic       res_valid;
  logic       res_stall;
  logic       frame_end;
  logic [7:0] data_byte;
  logic [2:0] status;
  logic [5:0] frame_bytes;
  int         mismatches;
  int         outstanding;

  logic [7:0] line_q[$];
  int         sent = 0;
  int         gap_pct = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  always #4 clk = ~clk;

  modbus_ascii_frame_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_char    (rx_char),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .frame_end  (frame_end),
    .data_byte  (data_byte),
    .status     (status),
    .frame_bytes(frame_bytes)
  );

  mafd_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_char    (rx_char),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .frame_end  (frame_end),
    .data_byte  (data_byte),
    .status     (status),
    .frame_bytes(frame_bytes),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + 8'(v);
    end else begin
      c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    end
    return c;
  endfunction

  task automatic add_char(input logic [7:0] c);
    line_q.insert(line_q.size(), c);
  endtask

  task automatic push_byte(input logic [7:0] b);
    add_char(hex_char(b[7:4]));
    add_char(hex_char(b[3:0]));
  endtask

  // each character is one transfer, with an optional idle burst before it
  task automatic send_line();
    foreach (line_q[i]) begin
      if ($urandom_range(0, 99) < gap_pct) begin
        rx_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      rx_valid <= 1'b1;
      rx_char <= line_q[i];
      @(posedge clk);
      while (rx_stall) @(posedge clk);
      sent++;
    end
    line_q.delete();
  endtask

  task automatic build_frame(input frame_kind_t kind, input int n_data);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'd0;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) begin
        add_char(CHAR_CR);
        add_char(CHAR_LF);
      end
    end else begin
      if (kind == FR_START) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_COLON) b = b ^ 8'h01;
        add_char(b);
      end else begin
        add_char(CHAR_COLON);
      end
      if (kind == FR_OVER) begin
        while (line_q.size() < MAX_FRAME_CHARS) add_char(hex_char(4'($urandom)));
        add_char($urandom_range(0, 1) ? CHAR_CR : hex_char(4'($urandom)));
      end else begin
        if (kind == FR_SHORT) begin
          repeat ($urandom_range(0, 2)) add_char(hex_char(4'($urandom)));
        end else begin
          repeat (n_data) begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            push_byte(b);
          end
          b = 8'd0 - sum;
          if (kind == FR_LRC) b = b ^ 8'($urandom_range(1, 255));
          push_byte(b);
        end
        case (kind)
          FR_HEX: begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
            line_q[$urandom_range(1, line_q.size() - 1)] = b;
          end
          FR_ODD: line_q.delete($urandom_range(1, line_q.size() - 1));
          FR_CR:  line_q.insert($urandom_range(1, line_q.size() - 1), CHAR_CR);
          FR_LF:  line_q.insert($urandom_range(1, line_q.size()), CHAR_LF);
          default: ;
        endcase
        add_char(CHAR_CR);
        add_char(CHAR_LF);
      end
    end
  endtask

  // result side: random stall bursts and one long hold-off
  initial begin
    res_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < gap_pct) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    frame_kind_t kind;
    int          pick;
    int          n_data;
    int          block_end;
    rst <= 1'b1;
    rx_valid <= 1'b0;
    rx_char <= 8'd0;
    block_end = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // extremes of the character, a minimum-length frame in mixed case, odd length over bad hex
    line_q = '{8'h00, 8'hFF, CHAR_CR, CHAR_LF};
    send_line();
    line_q = '{CHAR_COLON, "1", "a", "E", "6", CHAR_CR, CHAR_LF};
    send_line();
    line_q = '{CHAR_COLON, "0", "1", CHAR_LF, "F", "f", CHAR_CR, CHAR_LF};
    send_line();

    while (sent < N_ITEMS) begin
      if (sent >= block_end) begin
        block_end = sent + 150;
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (sent >= CALM_AT) gap_pct = 0;
      if (!hold_req && sent >= HOLD_AT) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = FR_GOOD;
      else if (pick < 53) kind = FR_LRC;
      else if (pick < 61) kind = FR_HEX;
      else if (pick < 67) kind = FR_ODD;
      else if (pick < 72) kind = FR_START;
      else if (pick < 77) kind = FR_SHORT;
      else if (pick < 82) kind = FR_CR;
      else if (pick < 87) kind = FR_LF;
      else if (pick < 89) kind = FR_OVER;
      else kind = FR_NOISE;
      if ($urandom_range(0, 30) == 0) n_data = 62;
      else if ($urandom_range(0, 9) == 0) n_data = $urandom_range(1, 62);
      else n_data = $urandom_range(1, 6);
      build_frame(kind, n_data);
      send_line();
    end
    rx_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("modbus_ascii_frame_decoder: match");
    end else begin
      $display("modbus_ascii_frame_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("modbus_ascii_frame_decoder: mismatch");
    $finish;
  end

endmodule
